[src/ktlf_pkg.sv]
package ktlf_pkg;

   // matrix geometry
   localparam int NUM_ROWS = 4;
   localparam int NUM_COLS = 16;
   localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
   localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   // command codes
   localparam logic [1:0] CMD_KEY   = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_STEP      = 2'd1;
   localparam logic [1:0] REG_HIGHLIGHT = 2'd2;
   localparam logic [1:0] REG_INACTIVE  = 2'd3;

   localparam logic [15:0] STEP_RESET = 16'd50;
   localparam logic [7:0]  LEVEL_FULL = 8'hff;

   // store control bundle from the sequencer
   typedef struct packed {
      logic             we;
      logic [KEY_W-1:0] waddr;
      logic [7:0]       wdata;
      logic [KEY_W-1:0] raddr;
      logic             clear;
   } st_ctl_type;

   // one decay step of an intensity
   function automatic logic [7:0] decay_level(input logic [7:0] v);
      logic [7:0] r;
      if (v >= 8'hf0) begin
         r = v - 8'd1;
      end else if (v >= 8'h40) begin
         r = v - 8'd16;
      end else if (v >= 8'd32) begin
         r = v - 8'd32;
      end else begin
         r = 8'd0;
      end
      return r;
   endfunction

endpackage

[src/ktlf_scale.sv]
// shared scaler: level * chan / 255, product registered, divide by 255 via add and shift
module ktlf_scale import ktlf_pkg::*; (
   input  logic       clock,
   input  logic [7:0] level,
   input  logic [7:0] chan,
   output logic [7:0] quotient
);

   logic [15:0] product_ff;
   logic [15:0] product_in;
   logic [16:0] sum;

   // multiply stage
   assign product_in = 16'(level) * 16'(chan);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // exact floor(x / 255) for x up to 255 * 255
   assign sum      = 17'(product_ff) + 17'(product_ff[15:8]) + 17'd1;
   assign quotient = sum[15:8];

endmodule

[src/ktlf_store.sv]
// intensity store: one write port, one registered read port, valid bits per entry
module ktlf_store import ktlf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  st_ctl_type ctl,
   output logic [7:0] rdata
);

   logic [7:0]          mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] vld_ff;
   logic [NUM_KEYS-1:0] vld_in;
   logic [7:0]          rdata_ff;
   logic                rvld_ff;

   // memory array
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata_ff <= mem[ctl.raddr];
   end

   // valid bits, cleared together
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end else if (ctl.we) begin
         vld_in[ctl.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         rvld_ff <= vld_ff[ctl.raddr];
      end
   end

   // entry never written since clear reads as zero
   assign rdata = rvld_ff ? rdata_ff : 8'd0;

endmodule

[src/key_trail_led_fader_top.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | cmd, key_row, key_col, key_pressed, now_ms
// rsp     | out       | rsp_valid/rsp_ready  | led_row, led_col, red, green, blue, last
// csr     | in/out    | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// key events and clear commands leave the sequencer idle; req_ready stays high.
// an enabled tick walks each key through a store read, three passes through the
// shared scaler and an emit, and waits in the emit while rsp stalls.
// the store has per-entry valid bits, so reset and clear take effect at once.
// rsp is a register: the next request is taken while the final result waits.
module key_trail_led_fader_top import ktlf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [2:0]          req_key_row,
   input  logic [4:0]          req_key_col,
   input  logic                req_key_pressed,
   input  logic [15:0]         req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_led_row,
   output logic [3:0]          rsp_led_col,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_MR   = 3'd2;
   localparam logic [2:0] ST_MG   = 3'd3;
   localparam logic [2:0] ST_MB   = 3'd4;
   localparam logic [2:0] ST_MF   = 3'd5;
   localparam logic [2:0] ST_EM   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             tout_ff, tout_in;
   logic [7:0]       level_ff, level_in;
   logic [7:0]       red_ff, red_in;
   logic [7:0]       grn_ff, grn_in;
   logic [7:0]       blu_ff, blu_in;
   logic             enable_ff;
   logic [15:0]      step_ff;
   logic [23:0]      hl_ff;
   logic [23:0]      ina_ff;
   logic [15:0]      dstart_ff, dstart_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_row_ff, rsp_row_in;
   logic [3:0]       rsp_col_ff, rsp_col_in;
   logic [23:0]      rsp_rgb_ff, rsp_rgb_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_xfer;
   logic             csr_wr;
   logic             key_hit;
   logic             scan_last;
   logic             em_fire;
   logic [15:0]      elapsed;
   logic [KEY_W-1:0] scan_addr;
   logic [KEY_W-1:0] key_addr;
   logic [7:0]       new_level;
   logic [7:0]       st_rdata;
   logic [7:0]       sc_level;
   logic [7:0]       sc_chan;
   logic [7:0]       sc_q;
   st_ctl_type       st_ctl;

   // shared scaler and intensity store
   ktlf_scale u_scale (
      .clock    (clock),
      .level    (sc_level),
      .chan     (sc_chan),
      .quotient (sc_q)
   );

   ktlf_store u_store (
      .clock (clock),
      .reset (reset),
      .ctl   (st_ctl),
      .rdata (st_rdata)
   );

   // handshake and address decode
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;

   assign key_hit   = (32'(req_key_row) < NUM_ROWS) && (32'(req_key_col) < NUM_COLS)
                      && req_key_pressed;
   assign key_addr  = KEY_W'(32'(req_key_row) * NUM_COLS + 32'(req_key_col));
   assign scan_addr = KEY_W'(32'(row_ff) * NUM_COLS + 32'(col_ff));
   assign scan_last = (32'(row_ff) == NUM_ROWS - 1) && (32'(col_ff) == NUM_COLS - 1);
   assign elapsed   = req_now_ms - dstart_ff;
   assign em_fire   = (state_ff == ST_EM) && (!rsp_valid_ff || rsp_ready);
   assign new_level = tout_ff ? decay_level(level_ff) : level_ff;

   // scaler operand select per pass
   always_comb begin
      sc_level = level_ff;
      sc_chan  = hl_ff[7:0];
      case (state_ff)
         ST_MR: begin
            sc_level = st_rdata;
            sc_chan  = hl_ff[23:16];
         end
         ST_MG: begin
            sc_chan = hl_ff[15:8];
         end
         default: begin
            sc_chan = hl_ff[7:0];
         end
      endcase
   end

   // store control: key press write, scan write-back, clear
   always_comb begin
      st_ctl.raddr = scan_addr;
      st_ctl.clear = req_xfer && (req_cmd == CMD_CLEAR);
      if (em_fire) begin
         st_ctl.we    = tout_ff;
         st_ctl.waddr = scan_addr;
         st_ctl.wdata = new_level;
      end else begin
         st_ctl.we    = req_xfer && (req_cmd == CMD_KEY) && key_hit;
         st_ctl.waddr = key_addr;
         st_ctl.wdata = LEVEL_FULL;
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      tout_in      = tout_ff;
      level_in     = level_ff;
      red_in       = red_ff;
      grn_in       = grn_ff;
      blu_in       = blu_ff;
      dstart_in    = dstart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_cmd == CMD_TICK) && enable_ff) begin
               state_in = ST_RD;
               row_in   = '0;
               col_in   = '0;
               tout_in  = (elapsed > step_ff);
               if (elapsed > step_ff) begin
                  dstart_in = req_now_ms;
               end
            end
         end
         ST_RD: begin
            state_in = ST_MR;
         end
         ST_MR: begin
            level_in = st_rdata;
            state_in = ST_MG;
         end
         ST_MG: begin
            red_in   = sc_q;
            state_in = ST_MB;
         end
         ST_MB: begin
            grn_in   = sc_q;
            state_in = ST_MF;
         end
         ST_MF: begin
            blu_in   = sc_q;
            state_in = ST_EM;
         end
         ST_EM: begin
            if (em_fire) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = 2'(row_ff);
               rsp_col_in   = 4'(col_ff);
               rsp_last_in  = scan_last;
               rsp_rgb_in   = (new_level == 8'd0) ? ina_ff : {red_ff, grn_ff, blu_ff};
               if (scan_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD;
                  if (32'(col_ff) == NUM_COLS - 1) begin
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dstart_ff    <= '0;
         enable_ff    <= 1'b0;
         step_ff      <= STEP_RESET;
         hl_ff        <= '0;
         ina_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dstart_ff    <= dstart_in;
         if (csr_wr) begin
            case (paddr[3:2])
               REG_ENABLE:    enable_ff <= pwdata[0];
               REG_STEP:      step_ff   <= pwdata[15:0];
               REG_HIGHLIGHT: hl_ff     <= pwdata[23:0];
               REG_INACTIVE:  ina_ff    <= pwdata[23:0];
               default:       enable_ff <= enable_ff;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      tout_ff     <= tout_in;
      level_ff    <= level_in;
      red_ff      <= red_in;
      grn_ff      <= grn_in;
      blu_ff      <= blu_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_rgb_ff  <= rsp_rgb_in;
      rsp_last_ff <= rsp_last_in;
   end

   // register readback
   always_comb begin
      case (paddr[3:2])
         REG_ENABLE:    prdata = {31'd0, enable_ff};
         REG_STEP:      prdata = {16'd0, step_ff};
         REG_HIGHLIGHT: prdata = {8'd0, hl_ff};
         REG_INACTIVE:  prdata = {8'd0, ina_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // result outputs
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_led_row = rsp_row_ff;
   assign rsp_led_col = rsp_col_ff;
   assign rsp_red     = rsp_rgb_ff[23:16];
   assign rsp_green   = rsp_rgb_ff[15:8];
   assign rsp_blue    = rsp_rgb_ff[7:0];
   assign rsp_last    = rsp_last_ff;

`ifndef ASSERT_OFF
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_cmd == CMD_TICK) && enable_ff)
      |=> (state_ff == ST_RD) && (row_ff == '0) && (col_ff == '0))
      else $error("enabled tick did not start scan at first key");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (em_fire && scan_last) |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("scan did not finish after final key");

   a_scan_write: assert property (@(posedge clock) disable iff (reset)
      (st_ctl.we && (state_ff != ST_IDLE)) |-> (state_ff == ST_EM))
      else $error("store written mid-scan outside emit");

   a_decay_wb: assert property (@(posedge clock) disable iff (reset)
      (em_fire && tout_ff) |-> (st_ctl.we && (st_ctl.waddr == scan_addr)))
      else $error("decayed level not written back");
`endif

endmodule

[test/key_trail_led_fader_top_tb.sv]
`timescale 1ns / 100ps

module key_trail_led_fader_top_tb;
   import ktlf_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES = 600;
   localparam int PHASE_ITEMS = 44;
   localparam int PRINT_LIMIT = 100;
   localparam int CYCLE_LIMIT = 4_000_000;

   // one led color as it leaves the block
   typedef struct packed {
      logic [ROW_W-1:0] led_row;
      logic [COL_W-1:0] led_col;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic             last;
   } led_type;

   // trail state and the led colors each accepted request should produce
   class trail_scoreboard;
      logic [7:0]  level [NUM_KEYS];
      logic [15:0] decay_start;
      logic        enable;
      logic [15:0] step_ms;
      logic [23:0] highlight;
      logic [23:0] inactive;
      led_type     expected_leds [$];
      int          errors;

      function new();
         foreach (level[k]) level[k] = 8'd0;
         decay_start = 16'd0;
         enable = 1'b0;
         step_ms = STEP_RESET;
         highlight = 24'd0;
         inactive = 24'd0;
         errors = 0;
      endfunction

      task report_mismatch(string what);
         if (errors < PRINT_LIMIT) $display("ERROR: %s", what);
         errors++;
      endtask

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_ENABLE:    enable = value[0];
            REG_STEP:      step_ms = value[15:0];
            REG_HIGHLIGHT: highlight = value[23:0];
            REG_INACTIVE:  inactive = value[23:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] fade_step(logic [7:0] v);
         if (v >= 8'd240) return v - 8'd1;
         else if (v >= 8'd64) return v - 8'd16;
         else if (v >= 8'd32) return v - 8'd32;
         return 8'd0;
      endfunction

      function logic [7:0] scale_to_level(logic [7:0] lv, logic [7:0] chan);
         return 8'((int'(lv) * int'(chan)) / 255);
      endfunction

      // full row-major scan, decaying every key when the step time has passed
      function void predict_frame(logic [15:0] now);
         logic [15:0] elapsed;
         logic        decays;
         logic [7:0]  lv;
         led_type     e;
         elapsed = now - decay_start;
         decays = elapsed > step_ms;
         for (int k = 0; k < NUM_KEYS; k++) begin
            lv = level[k];
            e.led_row = ROW_W'(k / NUM_COLS);
            e.led_col = COL_W'(k % NUM_COLS);
            e.last = (k == NUM_KEYS - 1);
            e.red = scale_to_level(lv, highlight[23:16]);
            e.green = scale_to_level(lv, highlight[15:8]);
            e.blue = scale_to_level(lv, highlight[7:0]);
            if (decays) level[k] = fade_step(lv);
            // keys at zero, also those that just faded out, show the idle color
            if (level[k] == 8'd0) {e.red, e.green, e.blue} = inactive;
            expected_leds.push_back(e);
         end
         if (decays) decay_start = now;
      endfunction

      function void note_request(logic [1:0] cmd, logic [2:0] row, logic [4:0] col,
            logic pressed, logic [15:0] now);
         case (cmd)
            CMD_KEY: begin
               if (row < NUM_ROWS && col < NUM_COLS && pressed)
                  level[int'(row) * NUM_COLS + int'(col)] = LEVEL_FULL;
            end
            CMD_CLEAR: foreach (level[k]) level[k] = 8'd0;
            CMD_TICK: if (enable) predict_frame(now);
            default: ;
         endcase
      endfunction

      task compare_field(string name, int got, int want, led_type at);
         if (got != want)
            report_mismatch($sformatf("led %0d,%0d %s got %0d expected %0d",
               at.led_row, at.led_col, name, got, want));
      endtask

      task check_led(led_type got);
         led_type want;
         if (expected_leds.size() == 0) begin
            report_mismatch($sformatf("unexpected led transfer row %0d col %0d",
               got.led_row, got.led_col));
            return;
         end
         want = expected_leds.pop_front();
         compare_field("led_row", got.led_row, want.led_row, want);
         compare_field("led_col", got.led_col, want.led_col, want);
         compare_field("red", got.red, want.red, want);
         compare_field("green", got.green, want.green, want);
         compare_field("blue", got.blue, want.blue, want);
         compare_field("last", got.last, want.last, want);
      endtask

      task check_drained();
         if (expected_leds.size() != 0)
            report_mismatch($sformatf("%0d led transfers never arrived",
               expected_leds.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_KEY;
   logic [2:0]  req_key_row = 3'd0;
   logic [4:0]  req_key_col = 5'd0;
   logic        req_key_pressed = 1'b0;
   logic [15:0] req_now_ms = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_led_row;
   logic [3:0]  rsp_led_col;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   trail_scoreboard trail = new();
   bit          gapless = 1'b0;
   bit          squeeze_req = 1'b0;
   int          step_setting = 50;
   logic [15:0] ms_now = 16'd0;
   int          cycle_count = 0;

   key_trail_led_fader_top dut (.*);

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("key_trail_led_fader_top: mismatch");
         $finish;
      end
   end

   // one request transfer, then an optional idle gap
   task automatic offer_request(input logic [1:0] cmd, input logic [2:0] row,
         input logic [4:0] col, input logic pressed, input logic [15:0] now);
      int roll;
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_key_row <= row;
      req_key_col <= col;
      req_key_pressed <= pressed;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      trail.note_request(cmd, row, col, pressed, now);
      roll = $urandom_range(0, 99);
      if (gapless || roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every led has come back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (trail.expected_leds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle, then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      trail.set_reg(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // junk above each register's width must be dropped
   task automatic configure(input logic en, input logic [15:0] step,
         input logic [23:0] hl, input logic [23:0] ia);
      settle();
      csr_write(REG_ENABLE, {31'($urandom), en});
      csr_write(REG_STEP, {16'($urandom), step});
      csr_write(REG_HIGHLIGHT, {8'($urandom), hl});
      csr_write(REG_INACTIVE, {8'($urandom), ia});
      step_setting = step;
   endtask

   // mostly on-matrix presses and ticks with a moving clock, some noise
   task automatic random_request(output bit counted);
      int          roll;
      logic [1:0]  cmd;
      logic [2:0]  row;
      logic [4:0]  col;
      logic        pressed;
      logic [15:0] now;
      roll = $urandom_range(0, 99);
      row = 3'($urandom_range(0, 7));
      col = 5'($urandom_range(0, 31));
      pressed = 1'($urandom_range(0, 1));
      now = 16'($urandom_range(0, 65535));
      if (roll < 52) begin
         cmd = CMD_KEY;
         if ($urandom_range(0, 7) != 0) begin
            row = 3'($urandom_range(0, NUM_ROWS - 1));
            col = 5'($urandom_range(0, NUM_COLS - 1));
            pressed = ($urandom_range(0, 5) != 0);
         end
      end else if (roll < 94) begin
         cmd = CMD_TICK;
         if ($urandom_range(0, 19) != 0)
            ms_now = ms_now + 16'($urandom_range(0, 2 * step_setting + 2));
         else
            ms_now = 16'($urandom_range(0, 65535));
         now = ms_now;
      end else if (roll < 97) begin
         cmd = CMD_CLEAR;
      end else begin
         cmd = CMD_UNUSED;
      end
      counted = !(cmd == CMD_UNUSED ||
         (cmd == CMD_KEY && !(row < NUM_ROWS && col < NUM_COLS && pressed)));
      offer_request(cmd, row, col, pressed, now);
   endtask

   // led sink with random stalls, quiet stretches and one long hold-off
   initial begin : led_sink
      int      stall_left;
      int      quiet_left;
      bit      squeeze_done;
      led_type got;
      stall_left = 0;
      quiet_left = 0;
      squeeze_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.led_row = rsp_led_row;
            got.led_col = rsp_led_col;
            got.red = rsp_red;
            got.green = rsp_green;
            got.blue = rsp_blue;
            got.last = rsp_last;
            trail.check_led(got);
         end
         if (squeeze_req && !squeeze_done) begin
            // hold off long enough for the block to back up into req
            squeeze_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (quiet_left > 0) begin
               quiet_left--;
            end else if ($urandom_range(0, 49) == 0) begin
               quiet_left = $urandom_range(300, 600);
            end else if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(1, 3);
               else stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin : stimulus
      int useful;
      bit counted;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // still disabled after reset: tick gives nothing, presses land
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd100);
      offer_request(CMD_KEY, 3'd0, 5'd0, 1'b1, 16'hffff);
      offer_request(CMD_KEY, 3'(NUM_ROWS - 1), 5'(NUM_COLS - 1), 1'b1, 16'd0);
      // presses off the matrix and a release change nothing
      offer_request(CMD_KEY, 3'(NUM_ROWS), 5'd0, 1'b1, 16'd0);
      offer_request(CMD_KEY, 3'd7, 5'd31, 1'b1, 16'd0);
      offer_request(CMD_KEY, 3'd0, 5'(NUM_COLS), 1'b1, 16'd0);
      offer_request(CMD_KEY, 3'd1, 5'd1, 1'b0, 16'd0);
      offer_request(CMD_UNUSED, 3'd7, 5'd31, 1'b1, 16'hffff);

      // step zero: equal time holds, one ms decays, elapsed time wraps
      configure(1'b1, 16'd0, 24'hffffff, 24'h5aa53c);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd0);
      offer_request(CMD_TICK, 3'd7, 5'd31, 1'b1, 16'd1);
      offer_request(CMD_KEY, 3'd2, 5'd7, 1'b1, 16'd0);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'hffff);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd0);
      offer_request(CMD_CLEAR, 3'd5, 5'd19, 1'b1, 16'h1234);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd5);

      // widest step never times out, black highlight
      configure(1'b1, 16'hffff, 24'h000000, 24'hffffff);
      offer_request(CMD_KEY, 3'd1, 5'd3, 1'b1, 16'd0);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd4);
      offer_request(CMD_TICK, 3'd0, 5'd0, 1'b0, 16'd40000);
      ms_now = 16'd40000;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(1'b1, 16'd2, 24'($urandom), 24'($urandom));
            1: configure(1'b1, 16'd0, 24'hffffff, 24'h000000);
            2: configure(1'b0, 16'($urandom), 24'h000000, 24'hffffff);
            3: configure(1'b1, 16'hffff, 24'($urandom), 24'($urandom));
            4: configure(1'b1, 16'($urandom_range(0, 40)), 24'($urandom), 24'($urandom));
            default: configure(1'b1, 16'd1, 24'($urandom), 24'h000000);
         endcase
         gapless = (phase % 2 == 1);
         useful = 0;
         while (useful < PHASE_ITEMS) begin
            if (phase == 1 && useful == 6) squeeze_req = 1'b1;
            random_request(counted);
            if (counted) useful++;
         end
      end

      settle();
      trail.check_drained();
      if (trail.errors == 0) begin
         $display("key_trail_led_fader_top: match");
      end else begin
         $display("key_trail_led_fader_top: mismatch");
      end
      $finish;
   end

endmodule
